// ----- hdl/sbm_pkg.sv -----
// Shared types, codes and slot tables for the sensor register bus master.
// No dependencies; imported by every module of the block but the checker.
package sbm_pkg;

    localparam int unsigned BYTE_W   = 8;
    localparam int unsigned MODE_W   = 2;
    localparam int unsigned IDX_W    = 4;   // position in the segment program
    localparam int unsigned REM_W    = 5;   // slot within a segment, up to 23
    localparam int unsigned IN_DATA_W  = 24;
    localparam int unsigned OUT_DATA_W = 16;

    localparam logic [IDX_W-1:0] WRITE_LAST_IDX = 4'd8;
    localparam logic [IDX_W-1:0] READ_LAST_IDX  = 4'd12;

    typedef enum logic [MODE_W-1:0] {
        MODE_TICK  = 2'd0,
        MODE_WRITE = 2'd1,
        MODE_READ  = 2'd2,
        MODE_SPARE = 2'd3
    } mode_t;

    typedef enum logic [2:0] {
        SEG_IDLE  = 3'd0,
        SEG_START = 3'd1,
        SEG_WBYTE = 3'd2,
        SEG_ACK   = 3'd3,
        SEG_STOP  = 3'd4,
        SEG_RBYTE = 3'd5,
        SEG_NACK  = 3'd6
    } seg_kind_t;

    typedef enum logic [1:0] {
        SRC_ADDR  = 2'd0,
        SRC_REG   = 2'd1,
        SRC_VAL   = 2'd2,
        SRC_RADDR = 2'd3
    } src_sel_t;

    typedef struct packed {
        seg_kind_t kind;
        src_sel_t  src;
    } prog_entry_t;

    typedef struct packed {
        logic [MODE_W-1:0] mode;
        logic [BYTE_W-1:0] register_index;
        logic [BYTE_W-1:0] write_value;
        logic              sda_sample;
    } item_t;

    typedef struct packed {
        logic              scl_level;
        logic              sda_level;
        logic              busy_res;
        logic              done_res;
        logic [BYTE_W-1:0] read_data;
        logic              ack_error;
    } result_t;

    // last slot number of each segment kind
    function automatic logic [REM_W-1:0] seg_last(input seg_kind_t kind);
        logic [REM_W-1:0] r;
        r = '0;
        case (kind)
            SEG_IDLE:  r = 5'd0;
            SEG_START: r = 5'd1;
            SEG_WBYTE: r = 5'd23;
            SEG_ACK:   r = 5'd2;
            SEG_STOP:  r = 5'd2;
            SEG_RBYTE: r = 5'd15;
            SEG_NACK:  r = 5'd1;
            default:   r = 5'd0;
        endcase
        return r;
    endfunction

    // segment programs for a register write and a register read
    function automatic prog_entry_t prog_entry(input logic is_read,
                                               input logic [IDX_W-1:0] idx);
        prog_entry_t e;
        e = '{kind: SEG_IDLE, src: SRC_ADDR};
        if (is_read) begin
            case (idx)
                4'd0:    e = '{kind: SEG_IDLE,  src: SRC_ADDR};
                4'd1:    e = '{kind: SEG_START, src: SRC_ADDR};
                4'd2:    e = '{kind: SEG_WBYTE, src: SRC_ADDR};
                4'd3:    e = '{kind: SEG_ACK,   src: SRC_ADDR};
                4'd4:    e = '{kind: SEG_WBYTE, src: SRC_REG};
                4'd5:    e = '{kind: SEG_ACK,   src: SRC_ADDR};
                4'd6:    e = '{kind: SEG_STOP,  src: SRC_ADDR};
                4'd7:    e = '{kind: SEG_START, src: SRC_ADDR};
                4'd8:    e = '{kind: SEG_WBYTE, src: SRC_RADDR};
                4'd9:    e = '{kind: SEG_ACK,   src: SRC_ADDR};
                4'd10:   e = '{kind: SEG_RBYTE, src: SRC_ADDR};
                4'd11:   e = '{kind: SEG_NACK,  src: SRC_ADDR};
                4'd12:   e = '{kind: SEG_STOP,  src: SRC_ADDR};
                default: e = '{kind: SEG_IDLE,  src: SRC_ADDR};
            endcase
        end else begin
            case (idx)
                4'd0:    e = '{kind: SEG_IDLE,  src: SRC_ADDR};
                4'd1:    e = '{kind: SEG_START, src: SRC_ADDR};
                4'd2:    e = '{kind: SEG_WBYTE, src: SRC_ADDR};
                4'd3:    e = '{kind: SEG_ACK,   src: SRC_ADDR};
                4'd4:    e = '{kind: SEG_WBYTE, src: SRC_REG};
                4'd5:    e = '{kind: SEG_ACK,   src: SRC_ADDR};
                4'd6:    e = '{kind: SEG_WBYTE, src: SRC_VAL};
                4'd7:    e = '{kind: SEG_ACK,   src: SRC_ADDR};
                4'd8:    e = '{kind: SEG_STOP,  src: SRC_ADDR};
                default: e = '{kind: SEG_IDLE,  src: SRC_ADDR};
            endcase
        end
        return e;
    endfunction

endpackage

// ----- hdl/sbm_seq.sv -----
// Bus slot sequencer: transfer state and per-slot line levels for one item.
// Depends on sbm_pkg.
module sbm_seq (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  advance,
    input  sbm_pkg::item_t        item,
    input  logic [7:0]            sensor_address,
    output sbm_pkg::result_t      result
);
    import sbm_pkg::*;

    logic              active_reg, active_next;
    logic              is_read_reg, is_read_next;
    logic [IDX_W-1:0]  idx_reg, idx_next;
    logic [REM_W-1:0]  rem_reg, rem_next;
    logic [BYTE_W-1:0] shift_reg, shift_next;
    logic [BYTE_W-1:0] saved_register_reg, saved_register_next;
    logic [BYTE_W-1:0] saved_value_reg, saved_value_next;

    prog_entry_t       entry;
    logic [REM_W-1:0]  last_rem;
    logic              last_seg;
    logic [BYTE_W-1:0] tx_byte;
    logic [8:0]        div_prod;
    logic [2:0]        bit_q;
    logic [REM_W-1:0]  q_times3;
    logic [REM_W-1:0]  phase;
    logic              scl, sda, abort_now;

    assign entry    = prog_entry(is_read_reg, idx_reg);
    assign last_rem = seg_last(entry.kind);
    assign last_seg = idx_reg == (is_read_reg ? READ_LAST_IDX : WRITE_LAST_IDX);

    // rem / 3 for rem <= 23 via multiply by 11 and shift
    assign div_prod = {4'd0, rem_reg} * 9'd11;
    assign bit_q    = div_prod[7:5];
    assign q_times3 = {1'b0, bit_q, 1'b0} + {2'b00, bit_q};
    assign phase    = rem_reg - q_times3;

    always_comb
    begin
        case (entry.src)
            SRC_ADDR:  tx_byte = sensor_address;
            SRC_REG:   tx_byte = saved_register_reg;
            SRC_VAL:   tx_byte = saved_value_reg;
            SRC_RADDR: tx_byte = sensor_address + 8'd1;
            default:   tx_byte = sensor_address;
        endcase
    end

    always_comb
    begin
        active_next         = active_reg;
        is_read_next        = is_read_reg;
        idx_next            = idx_reg;
        rem_next            = rem_reg;
        shift_next          = shift_reg;
        saved_register_next = saved_register_reg;
        saved_value_next    = saved_value_reg;
        scl                 = 1'b1;
        sda                 = 1'b1;
        abort_now           = 1'b0;
        result              = '{scl_level: 1'b1, sda_level: 1'b1, busy_res: 1'b0,
                                done_res: 1'b0, read_data: '0, ack_error: 1'b0};

        if (!active_reg) begin
            if (item.mode == MODE_WRITE || item.mode == MODE_READ) begin
                saved_register_next = item.register_index;
                saved_value_next    = item.write_value;
                is_read_next        = item.mode == MODE_READ;
                shift_next          = '0;
                idx_next            = '0;
                rem_next            = '0;
                active_next         = 1'b1;
                result.busy_res     = 1'b1;
            end
        end else begin
            unique case (entry.kind)
                SEG_IDLE:
                begin
                    scl = 1'b1;
                    sda = 1'b1;
                end
                SEG_START:
                begin
                    scl = rem_reg == '0;
                    sda = 1'b0;
                end
                SEG_WBYTE:
                begin
                    sda = tx_byte[3'd7 - bit_q];
                    scl = phase == 5'd1;
                end
                SEG_ACK:
                begin
                    sda = 1'b1;
                    scl = rem_reg == 5'd1;
                    abort_now = (rem_reg == 5'd1) && is_read_reg && item.sda_sample;
                end
                SEG_STOP:
                begin
                    scl = rem_reg != '0;
                    sda = rem_reg == 5'd2;
                end
                SEG_RBYTE:
                begin
                    sda = 1'b1;
                    scl = !rem_reg[0];
                    if (!rem_reg[0])
                        shift_next = {shift_reg[6:0], item.sda_sample};
                end
                SEG_NACK:
                begin
                    sda = 1'b1;
                    scl = rem_reg == '0;
                end
                default:
                begin
                    scl = 1'b1;
                    sda = 1'b1;
                end
            endcase

            if (abort_now) begin
                active_next      = 1'b0;
                result.done_res  = 1'b1;
                result.ack_error = 1'b1;
            end else if (last_seg && rem_reg == last_rem) begin
                active_next      = 1'b0;
                result.scl_level = scl;
                result.sda_level = sda;
                result.done_res  = 1'b1;
                result.read_data = is_read_reg ? shift_reg : '0;
            end else begin
                result.scl_level = scl;
                result.sda_level = sda;
                result.busy_res  = 1'b1;
                if (rem_reg == last_rem) begin
                    idx_next = idx_reg + 4'd1;
                    rem_next = '0;
                end else begin
                    rem_next = rem_reg + 5'd1;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            active_reg <= 1'b0;
        end else if (advance) begin
            active_reg <= active_next;
        end
    end

    // operands and slot position are only read while a transfer is active
    always_ff @(posedge clk)
    begin
        if (advance) begin
            is_read_reg        <= is_read_next;
            idx_reg            <= idx_next;
            rem_reg            <= rem_next;
            shift_reg          <= shift_next;
            saved_register_reg <= saved_register_next;
            saved_value_reg    <= saved_value_next;
        end
    end

endmodule

// ----- hdl/sccb_bitbang_register_master_core.sv -----
// Top level of the two-wire sensor register master: stream ports, input
// and result registers, config register. Depends on sbm_pkg and sbm_seq.
//
// Channel   Dir  Handshake               Payload
// s_axis    in   s_tvalid / s_tready     s_tuser = mode, s_tdata = operands
// m_axis    out  m_tvalid / m_tready     m_tdata = lines and status
// cfg       in   cfg_valid / cfg_ready   cfg_data = sensor_address
//
// Every transaction is one bus slot; one item per clock is sustained while
// m_tready is high, and each item's result passes the input register, then
// the result register. The sequencer's slot state updates once per item.
// Reset clears the handshake valids and returns the sequencer to idle.
// A stalled m_tready holds the result register; the input register then
// holds too and s_tready drops only once both are occupied.
// Config is taken every cycle (cfg_ready is always high); writes are
// expected only while the block is idle.
module sccb_bitbang_register_master_core (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [23:0] s_tdata,   // [7:0] register_index, [15:8] write_value,
                                   // [16] sda_sample, [23:17] zero
    input  logic [1:0]  s_tuser,   // [1:0] mode
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,   // [0] scl_level, [1] sda_level, [2] busy_res,
                                   // [3] done_res, [11:4] read_data,
                                   // [12] ack_error, [15:13] zero
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [7:0]  cfg_data
);
    import sbm_pkg::*;

    logic        in_valid_reg;
    item_t       in_item_reg;
    logic        out_valid_reg;
    result_t     out_result_reg;
    logic [7:0]  sensor_address_reg;
    logic        advance;
    result_t     seq_result;
    item_t       s_item;

    assign s_item = '{mode: s_tuser, register_index: s_tdata[7:0],
                      write_value: s_tdata[15:8], sda_sample: s_tdata[16]};

    // the sequencer consumes the held item whenever the result slot frees up
    assign advance   = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready  = !in_valid_reg || advance;
    assign cfg_ready = 1'b1;

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {3'b000, out_result_reg.ack_error, out_result_reg.read_data,
                       out_result_reg.done_res, out_result_reg.busy_res,
                       out_result_reg.sda_level, out_result_reg.scl_level};

    sbm_seq u_seq (
        .clk            (clk),
        .rst_n          (rst_n),
        .advance        (advance),
        .item           (in_item_reg),
        .sensor_address (sensor_address_reg),
        .result         (seq_result)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            in_valid_reg       <= 1'b0;
            out_valid_reg      <= 1'b0;
            sensor_address_reg <= '0;
        end else begin
            if (s_tvalid && s_tready)
                in_valid_reg <= 1'b1;
            else if (advance)
                in_valid_reg <= 1'b0;

            if (advance)
                out_valid_reg <= 1'b1;
            else if (m_tready)
                out_valid_reg <= 1'b0;

            if (cfg_valid && cfg_ready)
                sensor_address_reg <= cfg_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
            in_item_reg <= s_item;
        if (advance)
            out_result_reg <= seq_result;
    end

endmodule

// ----- hdl/sbm_checker.sv -----
// Port-level checks on the register master's result stream, bound to the
// top level. Depends on nothing but the top level's port names.
module sbm_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [15:0] m_tdata
);

    // stalled result holds
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result changed while stalled");

    // a finishing transaction is never still busy
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tdata[3] |-> !m_tdata[2])
        else $error("done with busy");

    // an acknowledge error ends the transaction with lines released, no data
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tdata[12] |-> m_tdata[3] && m_tdata[1:0] == 2'b11
                                    && m_tdata[11:4] == 8'd0)
        else $error("bad abort result");

    // read data and acknowledge errors only show with done
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tdata[3] |-> m_tdata[11:4] == 8'd0 && !m_tdata[12])
        else $error("data or error without done");

endmodule

bind sccb_bitbang_register_master_core sbm_checker u_sbm_checker (.*);

// ----- tb/sbm_slot_checker.sv -----
`timescale 1ns / 1ps
// Scoreboard for the sensor register bus master: predicts every bus slot
// from accepted input transactions and compares the result stream.
// Depends on sbm_pkg for the mode, segment and source codes.
module sbm_slot_checker (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [23:0] s_tdata,
    input  logic [1:0]  s_tuser,
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [15:0] m_tdata,
    input  logic        cfg_valid,
    input  logic        cfg_ready,
    input  logic [7:0]  cfg_data,
    output int          fail_count,
    output int          pending
);
    import sbm_pkg::*;

    // shadow of the sequencer
    logic [7:0] sens_addr;
    logic [6:0] slot_no;
    logic [7:0] rx_byte;
    logic       reading;
    logic [7:0] req_reg;
    logic [7:0] req_val;

    result_t expected_slots[$];

    function automatic int slot_span(input seg_kind_t k);
        case (k)
            SEG_START: return 2;
            SEG_WBYTE: return 24;
            SEG_ACK:   return 3;
            SEG_STOP:  return 3;
            SEG_RBYTE: return 16;
            SEG_NACK:  return 2;
            default:   return 1;
        endcase
    endfunction

    function automatic prog_entry_t segment_at(input logic rd, input int idx);
        prog_entry_t e;
        e = '{SEG_IDLE, SRC_ADDR};
        case (idx)
            1:  e = '{SEG_START, SRC_ADDR};
            2:  e = '{SEG_WBYTE, SRC_ADDR};
            3:  e = '{SEG_ACK, SRC_ADDR};
            4:  e = '{SEG_WBYTE, SRC_REG};
            5:  e = '{SEG_ACK, SRC_ADDR};
            6:  e = rd ? prog_entry_t'{SEG_STOP, SRC_ADDR}
                       : prog_entry_t'{SEG_WBYTE, SRC_VAL};
            7:  e = rd ? prog_entry_t'{SEG_START, SRC_ADDR}
                       : prog_entry_t'{SEG_ACK, SRC_ADDR};
            8:  e = rd ? prog_entry_t'{SEG_WBYTE, SRC_RADDR}
                       : prog_entry_t'{SEG_STOP, SRC_ADDR};
            9:  e = '{SEG_ACK, SRC_ADDR};
            10: e = '{SEG_RBYTE, SRC_ADDR};
            11: e = '{SEG_NACK, SRC_ADDR};
            12: e = '{SEG_STOP, SRC_ADDR};
            default: e = '{SEG_IDLE, SRC_ADDR};
        endcase
        return e;
    endfunction

    // advances the shadow sequencer by one slot and returns the line state
    function automatic result_t predict_slot(input item_t it);
        result_t     r;
        prog_entry_t e;
        prog_entry_t cur;
        int          n, idx, cur_idx, rem, len, cur_len, bitpos;
        logic        found, abort_now;
        logic [7:0]  b;
        r = '0;
        r.scl_level = 1'b1;
        r.sda_level = 1'b1;
        cur = '{SEG_IDLE, SRC_ADDR};
        cur_idx = 0;
        cur_len = 1;
        abort_now = 1'b0;
        found = 1'b0;
        if (slot_no == 7'd0) begin
            if (it.mode == MODE_WRITE || it.mode == MODE_READ) begin
                req_reg = it.register_index;
                req_val = it.write_value;
                reading = (it.mode == MODE_READ);
                rx_byte = 8'h00;
                slot_no = 7'd1;
                r.busy_res = 1'b1;
            end
            return r;
        end
        n = reading ? 13 : 9;
        rem = int'(slot_no) - 1;
        for (idx = 0; idx < n; idx++) begin
            if (!found) begin
                e = segment_at(reading, idx);
                len = slot_span(e.kind);
                if (rem < len) begin
                    found = 1'b1;
                    cur = e;
                    cur_idx = idx;
                    cur_len = len;
                end else begin
                    rem = rem - len;
                end
            end
        end
        if (!found) begin
            slot_no = 7'd0;
            r.done_res = 1'b1;
            return r;
        end
        case (cur.kind)
            SEG_START: begin
                r.scl_level = (rem == 0);
                r.sda_level = 1'b0;
            end
            SEG_WBYTE: begin
                case (cur.src)
                    SRC_ADDR: b = sens_addr;
                    SRC_REG:  b = req_reg;
                    SRC_VAL:  b = req_val;
                    default:  b = sens_addr + 8'd1;
                endcase
                bitpos = 7 - rem / 3;
                r.sda_level = b[bitpos];
                r.scl_level = (rem % 3 == 1);
            end
            SEG_ACK: begin
                r.scl_level = (rem == 1);
                abort_now = (rem == 1) && reading && it.sda_sample;
            end
            SEG_STOP: begin
                r.scl_level = (rem != 0);
                r.sda_level = (rem == 2);
            end
            SEG_RBYTE: begin
                r.scl_level = (rem % 2 == 0);
                if (rem % 2 == 0)
                    rx_byte = {rx_byte[6:0], it.sda_sample};
            end
            SEG_NACK: r.scl_level = (rem == 0);
            default: ;
        endcase
        if (abort_now) begin
            slot_no = 7'd0;
            r = '0;
            r.scl_level = 1'b1;
            r.sda_level = 1'b1;
            r.done_res = 1'b1;
            r.ack_error = 1'b1;
        end else if (cur_idx == n - 1 && rem == cur_len - 1) begin
            slot_no = 7'd0;
            r.done_res = 1'b1;
            r.read_data = reading ? rx_byte : 8'h00;
        end else begin
            slot_no = slot_no + 7'd1;
            r.busy_res = 1'b1;
        end
        return r;
    endfunction

    task automatic field_check(input string name, input int exp_v, input int act_v);
        if (exp_v != act_v) begin
            $error("%s expected %0d actual %0d", name, exp_v, act_v);
            fail_count++;
        end
    endtask

    always @(posedge clk or negedge rst_n) begin
        item_t   it;
        result_t exp_r;
        if (!rst_n) begin
            sens_addr = 8'h00;
            slot_no = 7'd0;
            rx_byte = 8'h00;
            reading = 1'b0;
            req_reg = 8'h00;
            req_val = 8'h00;
            expected_slots.delete();
            fail_count = 0;
            pending = 0;
        end else begin
            if (cfg_valid && cfg_ready)
                sens_addr = cfg_data;
            if (m_tvalid && m_tready) begin
                if (expected_slots.size() == 0) begin
                    $error("result transaction with nothing expected: %h", m_tdata);
                    fail_count++;
                end else begin
                    exp_r = expected_slots.pop_front();
                    field_check("scl_level", exp_r.scl_level, m_tdata[0]);
                    field_check("sda_level", exp_r.sda_level, m_tdata[1]);
                    field_check("busy_res", exp_r.busy_res, m_tdata[2]);
                    field_check("done_res", exp_r.done_res, m_tdata[3]);
                    field_check("read_data", exp_r.read_data, m_tdata[11:4]);
                    field_check("ack_error", exp_r.ack_error, m_tdata[12]);
                end
            end
            if (s_tvalid && s_tready) begin
                it.mode = s_tuser;
                it.register_index = s_tdata[7:0];
                it.write_value = s_tdata[15:8];
                it.sda_sample = s_tdata[16];
                expected_slots.push_back(predict_slot(it));
            end
            pending = expected_slots.size();
        end
    end

endmodule

// ----- tb/tb_sccb_bitbang_register_master_core.sv -----
`timescale 1ns / 1ps
// Testbench top for the sensor register bus master: clock, reset, stimulus
// and verdict. Depends on sbm_pkg, sbm_slot_checker and the block itself.
module tb_sccb_bitbang_register_master_core;
    import sbm_pkg::*;

    localparam int ITEM_TARGET = 1550;
    localparam int QUIET_FROM  = 1300;      // no random gaps or stalls past this many items
    localparam int CYCLE_LIMIT = 500000;

    // slot numbers within a read where the sequencer samples an acknowledge
    localparam int ACK_ADDR_SLOT  = 29;
    localparam int ACK_REG_SLOT   = 56;
    localparam int ACK_RADDR_SLOT = 88;
    localparam int WRITE_SLOTS    = 87;
    localparam int READ_SLOTS     = 110;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [23:0] s_tdata = '0;
    logic [1:0]  s_tuser = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [15:0] m_tdata;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [7:0]  cfg_data = '0;

    int fail_count;
    int pending;
    int items_sent = 0;
    int cycles = 0;
    int stall_left = 0;
    bit quiet = 1'b0;

    always begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    sccb_bitbang_register_master_core dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    sbm_slot_checker u_slot_checker (
        .clk        (clk),
        .rst_n      (rst_n),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tuser    (s_tuser),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_data   (cfg_data),
        .fail_count (fail_count),
        .pending    (pending)
    );

    // Watchdog; the bound is several times the slowest legal run.
    always @(posedge clk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("tb: failure");
            $finish;
        end
    end

    // Result side back-pressure: random stall bursts, started only while not quiet.
    always @(negedge clk) begin
        if (stall_left != 0) begin
            m_tready <= 1'b0;
            stall_left <= stall_left - 1;
        end else if (!quiet && $urandom_range(0, 11) == 0) begin
            m_tready <= 1'b0;
            stall_left <= $urandom_range(0, 8);
        end else begin
            m_tready <= 1'b1;
        end
    end

    // One input transaction. Entered at a falling edge; returns at the
    // falling edge after acceptance with tvalid still high, so the next
    // call can keep streaming without a bubble.
    task automatic send_item(input logic [1:0] mode, input logic [7:0] reg_idx,
                             input logic [7:0] wr_val, input logic sample);
        int gap;
        if (!quiet && $urandom_range(0, 7) == 0) begin
            gap = $urandom_range(1, 9);
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= mode;
        s_tdata  <= {7'd0, sample, wr_val, reg_idx};
        do @(posedge clk); while (!s_tready);
        @(negedge clk);
        items_sent++;
    endtask

    // Stop feeding and wait until every predicted slot has come back.
    // Always waits for a falling edge before returning, so tvalid is not
    // re-raised in the same step it was dropped.
    task automatic drain();
        s_tvalid <= 1'b0;
        do @(negedge clk); while (pending != 0);
    endtask

    // Address register write; the sequencer is idle once drained, since
    // every transfer below is run to its end.
    task automatic set_address(input logic [7:0] addr);
        drain();
        cfg_valid <= 1'b1;
        cfg_data  <= addr;
        do @(posedge clk); while (!cfg_ready);
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    // A whole register transfer: the request, then one tick per bus slot.
    //   bad_ack   : which read acknowledge comes back high (0 = none);
    //               the transfer stops there
    //   noise_pct : share of ticks replaced by stray requests or spare mode,
    //               which the busy sequencer has to ignore
    //   fill      : level on every tick sample but a read acknowledge, -1 for random bits
    //   pause_at  : slot before which the sender waits for a full drain
    task automatic run_transfer(input mode_t op, input logic [7:0] reg_idx,
                                input logic [7:0] wr_val, input int bad_ack,
                                input int noise_pct, input int fill,
                                input int pause_at);
        int         slots, k, ack_no;
        logic       sample;
        logic [1:0] mode;
        slots = (op == MODE_READ) ? READ_SLOTS : WRITE_SLOTS;
        send_item(op, reg_idx, wr_val, 1'($urandom_range(0, 1)));
        for (k = 1; k <= slots; k++) begin
            if (k == pause_at)
                drain();
            ack_no = 0;
            if (op == MODE_READ) begin
                if (k == ACK_ADDR_SLOT)  ack_no = 1;
                if (k == ACK_REG_SLOT)   ack_no = 2;
                if (k == ACK_RADDR_SLOT) ack_no = 3;
            end
            // write acks are never checked, so they get the fill level too
            if (ack_no != 0)
                sample = (ack_no == bad_ack);
            else if (fill < 0)
                sample = 1'($urandom_range(0, 1));
            else
                sample = fill[0];
            mode = MODE_TICK;
            if ($urandom_range(0, 99) < noise_pct)
                mode = 2'($urandom_range(1, 3));
            send_item(mode, 8'($urandom), 8'($urandom), sample);
            if (ack_no != 0 && ack_no == bad_ack)
                break;
        end
    endtask

    // Random transfer: mostly clean, some aborted reads, sometimes a
    // constant data pattern for the all-zero and all-one read bytes.
    task automatic random_transfer();
        mode_t op;
        int    bad_ack, fill, pause_at, pick;
        op = $urandom_range(0, 1) ? MODE_READ : MODE_WRITE;
        bad_ack = ($urandom_range(0, 4) == 0) ? $urandom_range(1, 3) : 0;
        pick = $urandom_range(0, 7);
        fill = (pick == 0) ? 0 : (pick == 1) ? 1 : -1;
        pause_at = ($urandom_range(0, 5) == 0) ? $urandom_range(1, WRITE_SLOTS) : 0;
        run_transfer(op, 8'($urandom), 8'($urandom), bad_ack, 6, fill, pause_at);
    endtask

    // Ticks and spare-mode items between transfers, sequencer idle.
    task automatic idle_items();
        int n, i;
        n = $urandom_range(0, 3);
        for (i = 0; i < n; i++)
            send_item($urandom_range(0, 1) ? MODE_SPARE : MODE_TICK,
                      8'($urandom), 8'($urandom), 1'($urandom_range(0, 1)));
    endtask

    initial begin
        int phase, done_in_phase;
        logic [7:0] addr;
        repeat (12) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // directed: read address wraps to zero with the top address
        set_address(8'hFF);
        send_item(MODE_TICK, 8'h00, 8'h00, 1'b0);
        send_item(MODE_SPARE, 8'hFF, 8'hFF, 1'b1);
        send_item(MODE_TICK, 8'hFF, 8'h00, 1'b1);
        // read whose address acknowledge is missing, with a drain inside
        run_transfer(MODE_READ, 8'hFF, 8'h00, 1, 0, -1, 12);
        send_item(MODE_TICK, 8'h00, 8'hFF, 1'b0);

        // random phases, each under its own sensor address
        phase = 1;
        done_in_phase = 0;
        while (items_sent < ITEM_TARGET) begin
            if (done_in_phase == 3) begin
                case (phase)
                    1:       addr = 8'hFE;
                    2:       addr = 8'h00;
                    default: addr = 8'($urandom);
                endcase
                set_address(addr);
                phase++;
                done_in_phase = 0;
            end
            quiet = (items_sent >= QUIET_FROM);
            idle_items();
            random_transfer();
            done_in_phase++;
        end

        quiet = 1'b1;
        drain();
        repeat (8) @(negedge clk);
        if (fail_count == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule

// ----- sim.f -----
hdl/sbm_pkg.sv
hdl/sbm_seq.sv
hdl/sccb_bitbang_register_master_core.sv
hdl/sbm_checker.sv
tb/sbm_slot_checker.sv
tb/tb_sccb_bitbang_register_master_core.sv
